[src/mm2p_pkg.sv]
`timescale 1ns / 1ps
package mm2p_pkg;

	localparam int EXP_BITS_DEF   = 63;
	localparam int VALUE_BITS_DEF = 31;
	localparam int CFG_IDX_BITS   = 3;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_MODULUS = 3'd0,
		REG_BASE_00 = 3'd1,
		REG_BASE_01 = 3'd2,
		REG_BASE_10 = 3'd3,
		REG_BASE_11 = 3'd4
	} cfg_reg_t;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_INIT = 5'b00010,
		ST_MUL  = 5'b00100,
		ST_SQR  = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

endpackage

[src/mm2p_dot.sv]
`timescale 1ns / 1ps
// Computes (a*b + c*d) mod m by interleaved shift-and-add, one bit of b and d per
// cycle, most significant first. a and c must be below m.
module mm2p_dot #(
	parameter int VALUE_BITS = mm2p_pkg::VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [VALUE_BITS-1:0] a,
	input  logic [VALUE_BITS-1:0] b,
	input  logic [VALUE_BITS-1:0] c,
	input  logic [VALUE_BITS-1:0] d,
	input  logic [VALUE_BITS-1:0] m,
	output logic                  done,
	output logic [VALUE_BITS-1:0] result
);
	import mm2p_pkg::*;

	localparam int CNT_BITS = $clog2(VALUE_BITS + 1);

	logic [CNT_BITS-1:0]   cnt_q;
	logic                  done_q;
	logic [VALUE_BITS-1:0] a_q, b_q, c_q, d_q, r_q;
	logic [VALUE_BITS+1:0] t, t1, m1, m2;
	logic [VALUE_BITS-1:0] r_next;

	always_comb begin
		m1 = {2'b00, m};
		m2 = {1'b0, m, 1'b0};
		t = {1'b0, r_q, 1'b0}
			+ (b_q[VALUE_BITS-1] ? {2'b00, a_q} : '0)
			+ (d_q[VALUE_BITS-1] ? {2'b00, c_q} : '0);
		// The sum stays below 4m, so two conditional subtractions bring it below m.
		t1 = (t >= m2) ? t - m2 : t;
		if (t1 >= m1) begin
			r_next = VALUE_BITS'(t1 - m1);
		end else begin
			r_next = VALUE_BITS'(t1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_BITS'(VALUE_BITS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			c_q <= c;
			d_q <= d;
			r_q <= '0;
		end else if (cnt_q != '0) begin
			b_q <= b_q << 1;
			d_q <= d_q << 1;
			r_q <= r_next;
		end
	end

	assign done   = done_q;
	assign result = r_q;

endmodule

[src/mod_matrix2x2_power_top.sv]
`timescale 1ns / 1ps
// Each matrix entry is computed on the shared multiply-reduce unit.
// An item costs 4 entries for the base reduction, then per exponent bit up to the highest
// set one: 4 entries if the bit is set, plus 4 for squaring unless it is the last bit.
// At the defaults that is at most 504 entries; a zero exponent takes only the 4 base entries.
// One item at a time; in_stall is high while an item is in flight.
// arst_n clears control and restores the register reset values (identity base, modulus 1).
module mod_matrix2x2_power_top #(
	parameter int EXP_BITS   = mm2p_pkg::EXP_BITS_DEF,
	parameter int VALUE_BITS = mm2p_pkg::VALUE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mm2p_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [VALUE_BITS-1:0]         cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [EXP_BITS-1:0]           exponent,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [VALUE_BITS-1:0]         res_00,
	output logic [VALUE_BITS-1:0]         res_01,
	output logic [VALUE_BITS-1:0]         res_10,
	output logic [VALUE_BITS-1:0]         res_11
);
	import mm2p_pkg::*;

	logic [VALUE_BITS-1:0] modulus_q, base_q [4];
	logic [VALUE_BITS-1:0] res_q [4], sq_q [4], tmp_q [4];
	logic [VALUE_BITS-1:0] out_q [4];
	logic [EXP_BITS-1:0]   exp_q;
	state_t                state_q;
	logic [1:0]            job_q;
	logic                  wait_q, out_valid_q;

	logic [VALUE_BITS-1:0] m_eff, one, x [4], y [4];
	logic [VALUE_BITS-1:0] op_a, op_b, op_c, op_d, dot_r;
	logic                  dot_start, dot_done;
	logic                  in_acc;

	assign m_eff = (modulus_q == '0) ? VALUE_BITS'(1) : modulus_q;
	assign one   = VALUE_BITS'(m_eff != VALUE_BITS'(1));
	assign in_acc = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			x[k] = sq_q[k];
			y[k] = sq_q[k];
		end
		if (state_q == ST_MUL) begin
			for (int k = 0; k < 4; k++) begin
				x[k] = res_q[k];
			end
		end
		// Entry (i,j) = x[i][0]*y[0][j] + x[i][1]*y[1][j].
		op_a = job_q[1] ? x[2] : x[0];
		op_c = job_q[1] ? x[3] : x[1];
		op_b = job_q[0] ? y[1] : y[0];
		op_d = job_q[0] ? y[3] : y[2];
		if (state_q == ST_INIT) begin
			// Reduce a base entry: one times the entry.
			op_a = one;
			op_b = base_q[job_q];
			op_c = '0;
			op_d = '0;
		end
	end

	assign dot_start = !wait_q &&
		(state_q == ST_INIT || state_q == ST_MUL || state_q == ST_SQR);

	mm2p_dot #(.VALUE_BITS(VALUE_BITS)) u_dot (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dot_start),
		.a      (op_a),
		.b      (op_b),
		.c      (op_c),
		.d      (op_d),
		.m      (m_eff),
		.done   (dot_done),
		.result (dot_r)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= VALUE_BITS'(1);
			base_q[0] <= VALUE_BITS'(1);
			base_q[1] <= '0;
			base_q[2] <= '0;
			base_q[3] <= VALUE_BITS'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODULUS: modulus_q <= cfg_data;
				REG_BASE_00: base_q[0] <= cfg_data;
				REG_BASE_01: base_q[1] <= cfg_data;
				REG_BASE_10: base_q[2] <= cfg_data;
				REG_BASE_11: base_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			job_q       <= '0;
			wait_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (dot_start) begin
				wait_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_INIT;
						job_q   <= '0;
					end
				end
				ST_INIT, ST_MUL, ST_SQR: begin
					if (dot_done) begin
						wait_q <= 1'b0;
						job_q  <= job_q + 1'b1;
						if (job_q == 2'd3) begin
							if (state_q == ST_INIT) begin
								if (exp_q == '0) begin
									state_q <= ST_DONE;
								end else if (exp_q[0]) begin
									state_q <= ST_MUL;
								end else begin
									state_q <= ST_SQR;
								end
							end else if (state_q == ST_MUL) begin
								if ((exp_q >> 1) == '0) begin
									state_q <= ST_DONE;
								end else begin
									state_q <= ST_SQR;
								end
							end else begin
								// The shifted exponent is known to be nonzero here.
								state_q <= exp_q[1] ? ST_MUL : ST_SQR;
							end
						end
					end
				end
				ST_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			exp_q    <= exponent;
			res_q[0] <= one;
			res_q[1] <= '0;
			res_q[2] <= '0;
			res_q[3] <= one;
		end
		if (dot_done) begin
			if (state_q == ST_INIT) begin
				sq_q[job_q] <= dot_r;
			end else begin
				tmp_q[job_q] <= dot_r;
			end
			if (job_q == 2'd3) begin
				if (state_q == ST_MUL) begin
					res_q[0] <= tmp_q[0];
					res_q[1] <= tmp_q[1];
					res_q[2] <= tmp_q[2];
					res_q[3] <= dot_r;
				end else if (state_q == ST_SQR) begin
					sq_q[0] <= tmp_q[0];
					sq_q[1] <= tmp_q[1];
					sq_q[2] <= tmp_q[2];
					sq_q[3] <= dot_r;
					exp_q   <= exp_q >> 1;
				end
			end
		end
		if (state_q == ST_DONE && (!out_valid_q || !out_stall)) begin
			for (int k = 0; k < 4; k++) begin
				out_q[k] <= res_q[k];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign res_00 = out_q[0];
	assign res_01 = out_q[1];
	assign res_10 = out_q[2];
	assign res_11 = out_q[3];

endmodule

[src/mm2p_checker.sv]
`timescale 1ns / 1ps
module mm2p_props (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall
);
	import mm2p_pkg::*;

	// A word waiting at the output is not dropped while stalled.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output word dropped while stalled");

	// Once an exponent is taken, no further one is taken until it is done.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while busy");

	// A result never appears right after an exponent is accepted.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !$rose(out_valid))
		else $error("result appeared too early");

endmodule

bind mod_matrix2x2_power_top mm2p_props u_mm2p_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall)
);

[tb/mm2p_checker.sv]
`timescale 1ns / 1ps
module mm2p_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [mm2p_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [mm2p_pkg::VALUE_BITS_DEF-1:0]  cfg_data,
	input  logic                                 in_valid,
	input  logic                                 in_stall,
	input  logic [mm2p_pkg::EXP_BITS_DEF-1:0]    exponent,
	input  logic                                 out_valid,
	input  logic                                 out_stall,
	input  logic [mm2p_pkg::VALUE_BITS_DEF-1:0]  res_00,
	input  logic [mm2p_pkg::VALUE_BITS_DEF-1:0]  res_01,
	input  logic [mm2p_pkg::VALUE_BITS_DEF-1:0]  res_10,
	input  logic [mm2p_pkg::VALUE_BITS_DEF-1:0]  res_11,
	output int                                   errors,
	output int                                   pending,
	output int                                   checked
);
	import mm2p_pkg::*;

	typedef struct {
		longint unsigned e00, e01, e10, e11;
	} mat_t;

	longint unsigned modulus, b00, b01, b10, b11;
	mat_t powers_q[$];

	function automatic mat_t mat_mul(mat_t x, mat_t y, longint unsigned m);
		mat_t r;
		r.e00 = (x.e00 * y.e00 + x.e01 * y.e10) % m;
		r.e01 = (x.e00 * y.e01 + x.e01 * y.e11) % m;
		r.e10 = (x.e10 * y.e00 + x.e11 * y.e10) % m;
		r.e11 = (x.e10 * y.e01 + x.e11 * y.e11) % m;
		return r;
	endfunction

	// Square-and-multiply from the low exponent bit; a zero modulus acts as one.
	function automatic mat_t matrix_power(logic [EXP_BITS_DEF-1:0] e);
		longint unsigned m;
		mat_t acc, sq;
		m = (modulus == 0) ? 1 : modulus;
		acc = '{1 % m, 0, 0, 1 % m};
		sq = '{b00 % m, b01 % m, b10 % m, b11 % m};
		for (int k = 0; k < EXP_BITS_DEF; k++) begin
			if (e[k])
				acc = mat_mul(acc, sq, m);
			sq = mat_mul(sq, sq, m);
		end
		return acc;
	endfunction

	task automatic report(string what, longint unsigned got, longint unsigned want);
		$display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus = 1;
			b00 = 1;
			b01 = 0;
			b10 = 0;
			b11 = 1;
			powers_q.delete();
			errors = 0;
			checked = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_MODULUS: modulus = cfg_data;
					REG_BASE_00: b00 = cfg_data;
					REG_BASE_01: b01 = cfg_data;
					REG_BASE_10: b10 = cfg_data;
					REG_BASE_11: b11 = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				powers_q.push_back(matrix_power(exponent));
			if (out_valid && !out_stall) begin
				if (powers_q.size() == 0) begin
					$display("%0t unexpected result word", $realtime);
					errors++;
				end else begin
					mat_t w;
					w = powers_q.pop_front();
					if (res_00 != w.e00) report("res_00", res_00, w.e00);
					if (res_01 != w.e01) report("res_01", res_01, w.e01);
					if (res_10 != w.e10) report("res_10", res_10, w.e10);
					if (res_11 != w.e11) report("res_11", res_11, w.e11);
					checked++;
				end
			end
			pending = powers_q.size();
		end
	end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
	import mm2p_pkg::*;

	localparam int WATCHDOG_LIMIT = 100000;
	localparam longint unsigned MOD_MAX = 64'h7FFF_FFFF;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [VALUE_BITS_DEF-1:0] cfg_data = '0;
	logic in_valid = 0;
	logic in_stall;
	logic [EXP_BITS_DEF-1:0] exponent = '0;
	logic out_valid;
	logic out_stall = 0;
	logic [VALUE_BITS_DEF-1:0] res_00, res_01, res_10, res_11;

	int errors, pending, checked;
	int idle_pct = 0;
	int stall_pct = 0;
	int sent = 0;
	int quiet_cycles = 0;
	int cfg_writes = 0;

	always #1 clk = ~clk;

	mod_matrix2x2_power_top dut (.*);

	mm2p_checker checker_i (.*);

	always @(posedge clk)
		out_stall <= ($urandom % 100) < stall_pct;

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no word moved in %0d cycles", WATCHDOG_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// The first edge lets the checker count a word accepted at the current edge.
	task automatic wait_idle();
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes all five registers back to back; the enable drops after the last one.
	task automatic load_config(longint unsigned m, longint unsigned a, longint unsigned b,
			longint unsigned c, longint unsigned d);
		longint unsigned vals[5];
		cfg_reg_t regs[5];
		vals = '{m, a, b, c, d};
		regs = '{REG_MODULUS, REG_BASE_00, REG_BASE_01, REG_BASE_10, REG_BASE_11};
		wait_idle();
		for (int i = 0; i < 5; i++) begin
			cfg_we <= 1;
			cfg_index <= regs[i];
			cfg_data <= vals[i][VALUE_BITS_DEF-1:0];
			cfg_writes++;
			@(posedge clk);
		end
		cfg_we <= 0;
	endtask

	task automatic send(logic [EXP_BITS_DEF-1:0] e);
		while (($urandom % 100) < idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		exponent <= e;
		do @(posedge clk); while (in_stall);
		sent++;
	endtask

	// Mostly short exponents keep the run short; a few reach the full width.
	function automatic logic [EXP_BITS_DEF-1:0] rand_exponent();
		int r, w;
		logic [63:0] v;
		r = $urandom % 100;
		w = (r < 85) ? $urandom_range(0, 5) : (r < 97) ? $urandom_range(6, 12)
			: $urandom_range(13, EXP_BITS_DEF);
		v = {$urandom, $urandom};
		v = (w == 0) ? 64'd0 : v & ((64'd1 << w) - 1);
		return v[EXP_BITS_DEF-1:0];
	endfunction

	function automatic longint unsigned below(longint unsigned m);
		longint unsigned v;
		v = {$urandom, $urandom};
		return (m == 0) ? 0 : v % m;
	endfunction

	task automatic random_config();
		longint unsigned m;
		int pick;
		pick = $urandom % 6;
		case (pick)
			0: m = 1;
			1: m = 2;
			2: m = $urandom_range(3, 1000);
			3: m = 0;
			4: m = MOD_MAX;
			default: m = $urandom_range(1000, 32'h7FFF_FFFF);
		endcase
		// Base entries sometimes exceed the modulus to exercise the pre-reduction.
		if ($urandom % 4 == 0)
			load_config(m, $urandom, $urandom, $urandom, $urandom);
		else
			load_config(m, below(m), below(m), below(m), below(m));
	endtask

	initial begin
		logic [EXP_BITS_DEF-1:0] all_ones;
		all_ones = '1;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Reset configuration: identity base, modulus one.
		send(0);
		send(5);
		in_valid <= 0;
		load_config(1_000_000_007, 1, 1, 1, 0);
		send(0);
		send(1);
		send(2);
		send(90);
		send(all_ones);
		send(EXP_BITS_DEF'(1) << (EXP_BITS_DEF - 1));
		in_valid <= 0;
		load_config(MOD_MAX, MOD_MAX - 1, MOD_MAX - 1, MOD_MAX - 1, MOD_MAX - 1);
		send(0);
		send(3);
		send(all_ones);
		in_valid <= 0;
		load_config(0, 3, 4, 5, 6);
		send(0);
		send(7);
		in_valid <= 0;
		load_config(7, MOD_MAX, 0, MOD_MAX, 8);
		send(0);
		send(13);
		send(all_ones);
		in_valid <= 0;
		load_config(2, 1, 1, 0, 1);
		send(4);
		send(all_ones);
		in_valid <= 0;
		// Writes to indexes past the register list must leave the setting alone.
		wait_idle();
		for (int i = int'(REG_BASE_11) + 1; i < (1 << CFG_IDX_BITS); i++) begin
			cfg_we <= 1;
			cfg_index <= CFG_IDX_BITS'(i);
			cfg_data <= VALUE_BITS_DEF'($urandom);
			cfg_writes++;
			@(posedge clk);
		end
		cfg_we <= 0;
		send(6);
		send(all_ones);
		in_valid <= 0;

		for (int ph = 0; ph < 6; ph++) begin
			random_config();
			case (ph % 4)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 86; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 86; end
				default: begin idle_pct = 22; stall_pct = 22; end
			endcase
			for (int n = 0; n < 140; n++) begin
				if (n == 70) begin
					in_valid <= 0;
					wait_idle();
				end
				send(rand_exponent());
			end
			in_valid <= 0;
		end
		idle_pct = 0;
		stall_pct = 0;

		wait_idle();
		repeat (200) @(posedge clk);
		$display("Sent %0d exponents over 12 settings (%0d register writes).", sent, cfg_writes);
		$display("Checked %0d result matrices under four idle and stall mixes.", checked);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

[mod_matrix2x2_power_top.f]
src/mm2p_pkg.sv
src/mm2p_dot.sv
src/mod_matrix2x2_power_top.sv
src/mm2p_checker.sv
tb/mm2p_checker.sv
tb/tb_top.sv
